@@ rtl/fwrm_pkg.sv @@
// ----------------------------------------------------------------------------
// fwrm_pkg: shared types and constants of the running-maximum FIFO
// Word and count sizes, operation codes, sequencer states, data selects,
// the out-stack entry layout and the sign-flip helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fwrm_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int TOTAL_W    = CNT_W + 1;

    typedef logic [WORD_WIDTH-1:0] word_t;

    // operation codes carried in the input tuser
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_XFER_RD,
        ST_XFER_WR,
        ST_POP_RD,
        ST_POP_WB,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        DSEL_ZERO,
        DSEL_POP,
        DSEL_MAX
    } data_sel_t;

    // out-stack entry: the word and the running maximum of everything below it
    typedef struct packed {
        word_t key;
        word_t prev_max;
    } out_entry_t;

    // Flip the sign bit: maps signed order onto unsigned order and back.
    function automatic word_t flip_sign(input word_t w);
        return {~w[WORD_WIDTH-1], w[WORD_WIDTH-2:0]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/fwrm_ram.sv @@
// ----------------------------------------------------------------------------
// fwrm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fwrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/fwrm_cmp.sv @@
// ----------------------------------------------------------------------------
// fwrm_cmp: shared maximum unit
// Unsigned compare of two sign-flipped words, returns the larger one.
// ----------------------------------------------------------------------------
`default_nettype none

module fwrm_cmp (
    input  wire fwrm_pkg::word_t a,
    input  wire fwrm_pkg::word_t b,
    output fwrm_pkg::word_t      max_o
);

    assign max_o = (a > b) ? a : b;

endmodule

`default_nettype wire

@@ rtl/fifo_with_running_max.sv @@
// ----------------------------------------------------------------------------
// fifo_with_running_max: FIFO of signed words with a running maximum
// Small sequencer, one shared compare unit; in-stack with one running max,
// out-stack with per-entry maxima. Push, pop, max query, empty/full flags.
// ----------------------------------------------------------------------------
// Steps from accept to result: push, query and unused kind run the execute
//   and response steps; a pop served by the out-stack adds a RAM read and a
//   write-back step; a pop that finds the out-stack empty first moves every
//   in-stack word over, one RAM read and one write each. A new item is taken
//   only in idle, after the result is placed in a free output register.
// Reset: both counts clear and both maxima return to the most negative word;
//   stack memories keep their contents and are never read before written.
`default_nettype none

module fifo_with_running_max (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] data, [63:32] current_max
    output logic [1:0]       m_tuser    // [0] empty_error, [1] full_error
);

    localparam int ADDR_W = fwrm_pkg::ADDR_W;
    localparam int CNT_W  = fwrm_pkg::CNT_W;

    fwrm_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]    in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    fwrm_pkg::word_t     in_max_reg, in_max_next;
    fwrm_pkg::word_t     out_max_reg, out_max_next;
    logic [1:0]          kind_reg, kind_next;
    fwrm_pkg::word_t     key_reg, key_next;
    fwrm_pkg::word_t     pop_key_reg, pop_key_next;
    fwrm_pkg::data_sel_t dsel_reg, dsel_next;
    logic                empty_err_reg, empty_err_next;
    logic                full_err_reg, full_err_next;
    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_data_reg, m_data_next;
    logic [1:0]          m_user_reg, m_user_next;

    // RAM ports
    logic                 in_wr_en, in_rd_en;
    logic [ADDR_W-1:0]    in_wr_addr, in_rd_addr;
    fwrm_pkg::word_t      in_rd_data;
    logic                 out_wr_en, out_rd_en;
    logic [ADDR_W-1:0]    out_wr_addr, out_rd_addr;
    fwrm_pkg::out_entry_t out_wr_data, out_rd_data;

    // shared compare unit
    fwrm_pkg::word_t cmp_a, cmp_b, cmp_max;

    logic [CNT_W-1:0]              in_cnt_m1, out_cnt_m1;
    logic [fwrm_pkg::TOTAL_W-1:0]  total;
    logic                          queue_full;
    fwrm_pkg::word_t               data_word;

    fwrm_ram #(
        .WIDTH (fwrm_pkg::WORD_WIDTH),
        .DEPTH (fwrm_pkg::DEPTH)
    ) u_in_stack (
        .aclk    (aclk),
        .wr_en   (in_wr_en),
        .wr_addr (in_wr_addr),
        .wr_data (key_reg),
        .rd_en   (in_rd_en),
        .rd_addr (in_rd_addr),
        .rd_data (in_rd_data)
    );

    fwrm_ram #(
        .WIDTH ($bits(fwrm_pkg::out_entry_t)),
        .DEPTH (fwrm_pkg::DEPTH)
    ) u_out_stack (
        .aclk    (aclk),
        .wr_en   (out_wr_en),
        .wr_addr (out_wr_addr),
        .wr_data (out_wr_data),
        .rd_en   (out_rd_en),
        .rd_addr (out_rd_addr),
        .rd_data (out_rd_data)
    );

    fwrm_cmp u_cmp (
        .a     (cmp_a),
        .b     (cmp_b),
        .max_o (cmp_max)
    );

    assign in_cnt_m1  = in_cnt_reg - CNT_W'(1);
    assign out_cnt_m1 = out_cnt_reg - CNT_W'(1);
    assign total      = {1'b0, in_cnt_reg} + {1'b0, out_cnt_reg};
    assign queue_full = (total >= fwrm_pkg::TOTAL_W'(fwrm_pkg::DEPTH));

    assign in_wr_addr  = in_cnt_reg[ADDR_W-1:0];
    assign in_rd_addr  = in_cnt_m1[ADDR_W-1:0];
    assign out_wr_addr = out_cnt_reg[ADDR_W-1:0];
    assign out_rd_addr = out_cnt_m1[ADDR_W-1:0];
    assign out_wr_data = '{key: in_rd_data, prev_max: out_max_reg};

    assign s_tready = (state_reg == fwrm_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // route operands to the compare unit by step
    always_comb begin
        case (state_reg)
            fwrm_pkg::ST_EXEC: begin
                cmp_a = key_reg;
                cmp_b = in_max_reg;
            end
            fwrm_pkg::ST_XFER_WR: begin
                cmp_a = in_rd_data;
                cmp_b = out_max_reg;
            end
            default: begin
                cmp_a = in_max_reg;
                cmp_b = out_max_reg;
            end
        endcase
    end

    always_comb begin
        case (dsel_reg)
            fwrm_pkg::DSEL_POP: data_word = fwrm_pkg::flip_sign(pop_key_reg);
            fwrm_pkg::DSEL_MAX: data_word = fwrm_pkg::flip_sign(cmp_max);
            default:            data_word = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fwrm_pkg::ST_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            in_max_reg  <= '0;
            out_max_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            in_max_reg  <= in_max_next;
            out_max_reg <= out_max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        pop_key_reg   <= pop_key_next;
        dsel_reg      <= dsel_next;
        empty_err_reg <= empty_err_next;
        full_err_reg  <= full_err_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    always_comb begin
        state_next     = state_reg;
        in_cnt_next    = in_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        in_max_next    = in_max_reg;
        out_max_next   = out_max_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        pop_key_next   = pop_key_reg;
        dsel_next      = dsel_reg;
        empty_err_next = empty_err_reg;
        full_err_next  = full_err_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        in_wr_en       = 1'b0;
        in_rd_en       = 1'b0;
        out_wr_en      = 1'b0;
        out_rd_en      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            fwrm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next      = s_tuser;
                    key_next       = fwrm_pkg::flip_sign(s_tdata);
                    empty_err_next = 1'b0;
                    full_err_next  = 1'b0;
                    dsel_next      = fwrm_pkg::DSEL_ZERO;
                    state_next     = fwrm_pkg::ST_EXEC;
                end
            end
            fwrm_pkg::ST_EXEC: begin
                state_next = fwrm_pkg::ST_RESP;
                case (kind_reg)
                    fwrm_pkg::KIND_PUSH: begin
                        if (queue_full) begin
                            full_err_next = 1'b1;
                        end else begin
                            in_wr_en    = 1'b1;
                            in_max_next = cmp_max;
                            in_cnt_next = in_cnt_reg + CNT_W'(1);
                        end
                    end
                    fwrm_pkg::KIND_POP: begin
                        if (in_cnt_reg == '0 && out_cnt_reg == '0) begin
                            empty_err_next = 1'b1;
                        end else begin
                            dsel_next  = fwrm_pkg::DSEL_POP;
                            state_next = (out_cnt_reg == '0) ? fwrm_pkg::ST_XFER_RD
                                                             : fwrm_pkg::ST_POP_RD;
                        end
                    end
                    fwrm_pkg::KIND_QUERY: begin
                        dsel_next = fwrm_pkg::DSEL_MAX;
                    end
                    default: begin
                        dsel_next = fwrm_pkg::DSEL_ZERO;
                    end
                endcase
            end
            fwrm_pkg::ST_XFER_RD: begin
                in_rd_en    = 1'b1;
                in_cnt_next = in_cnt_m1;
                state_next  = fwrm_pkg::ST_XFER_WR;
            end
            fwrm_pkg::ST_XFER_WR: begin
                out_wr_en    = 1'b1;
                out_max_next = cmp_max;
                out_cnt_next = out_cnt_reg + CNT_W'(1);
                if (in_cnt_reg == '0) begin
                    // in-stack drained: its maximum falls back to the floor
                    in_max_next = '0;
                    state_next  = fwrm_pkg::ST_POP_RD;
                end else begin
                    state_next  = fwrm_pkg::ST_XFER_RD;
                end
            end
            fwrm_pkg::ST_POP_RD: begin
                out_rd_en    = 1'b1;
                out_cnt_next = out_cnt_m1;
                state_next   = fwrm_pkg::ST_POP_WB;
            end
            fwrm_pkg::ST_POP_WB: begin
                pop_key_next = out_rd_data.key;
                out_max_next = out_rd_data.prev_max;
                state_next   = fwrm_pkg::ST_RESP;
            end
            fwrm_pkg::ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {fwrm_pkg::flip_sign(cmp_max), data_word};
                    m_user_next  = {full_err_reg, empty_err_reg};
                    state_next   = fwrm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fwrm_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= fwrm_pkg::TOTAL_W'(fwrm_pkg::DEPTH))
        else $error("stack counts exceed capacity");

    // the in-stack maximum clears in the transfer-write step that follows reading out the last word
    a_in_empty_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_cnt_reg == '0 && state_reg != fwrm_pkg::ST_XFER_WR) |-> (in_max_reg == '0))
        else $error("empty in-stack holds a nonzero maximum");

    // the out-stack maximum is restored in the write-back step that follows the count drop
    a_out_empty_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_cnt_reg == '0 && state_reg != fwrm_pkg::ST_POP_WB) |-> (out_max_reg == '0))
        else $error("empty out-stack holds a nonzero maximum");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fwrm_pkg::ST_POP_RD) |-> (out_cnt_reg != '0))
        else $error("pop issued on empty out-stack");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == fwrm_pkg::ST_RESP))
        else $error("result presented outside the response step");

endmodule

`default_nettype wire

@@ bench/tb_fifo_with_running_max.sv @@
// ----------------------------------------------------------------------------
// tb_fifo_with_running_max: self-checking bench for the running-max FIFO
// Drives push, pop, max query and unused-kind items into the input stream,
// checks every result against a plain-queue model or a typed row; a directed
// table covers the extremes, the empty pop, the full push and the unused kind.
// Random traffic follows under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fifo_with_running_max;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [fwrm_pkg::WORD_WIDTH-1:0] sword_t;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam sword_t     WORD_MIN    = {1'b1, {(fwrm_pkg::WORD_WIDTH-1){1'b0}}};
    localparam sword_t     WORD_MAX    = {1'b0, {(fwrm_pkg::WORD_WIDTH-1){1'b1}}};
    localparam int         RAND_ITEMS  = 1300;
    localparam int         HOLD_ITEMS  = 40;
    localparam int         HOLD_CYCLES = 400;

    typedef struct packed {
        sword_t data;
        sword_t cur_max;
        logic   empty_err;
        logic   full_err;
    } op_result_t;

    typedef struct packed {
        logic [1:0] kind;
        sword_t     value;
        int         reps;
        bit         typed;
        op_result_t res;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value
    logic [1:0]  s_tuser;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] data, [63:32] current_max
    logic [1:0]  m_tuser;   // [0] empty_error, [1] full_error

    sword_t     queue_words[$];
    op_result_t pending_results[$];

    int errors;
    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_go;
    bit rx_hold;
    int n_push, n_pop, n_query, n_unused, n_full, n_empty, peak_fill, n_checked;

    // directed rows; typed results are obvious, the rest go through the model
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{fwrm_pkg::KIND_POP,   32'sd0,        1,  1'b1, '{32'sd0,   WORD_MIN, 1'b1, 1'b0}},
        '{fwrm_pkg::KIND_QUERY, 32'sd0,        1,  1'b1, '{WORD_MIN, WORD_MIN, 1'b0, 1'b0}},
        '{KIND_UNUSED,          -32'sd1,       1,  1'b1, '{32'sd0,   WORD_MIN, 1'b0, 1'b0}},
        '{fwrm_pkg::KIND_PUSH,  WORD_MIN,      1,  1'b1, '{32'sd0,   WORD_MIN, 1'b0, 1'b0}},
        '{fwrm_pkg::KIND_QUERY, 32'sd0,        1,  1'b1, '{WORD_MIN, WORD_MIN, 1'b0, 1'b0}},
        '{fwrm_pkg::KIND_PUSH,  WORD_MAX,      1,  1'b1, '{32'sd0,   WORD_MAX, 1'b0, 1'b0}},
        '{fwrm_pkg::KIND_PUSH,  -32'sd1,       1,  1'b0, '0},
        '{fwrm_pkg::KIND_PUSH,  32'sd0,        1,  1'b0, '0},
        '{fwrm_pkg::KIND_PUSH,  32'sd1,        1,  1'b0, '0},
        '{fwrm_pkg::KIND_QUERY, 32'sd0,        1,  1'b1, '{WORD_MAX, WORD_MAX, 1'b0, 1'b0}},
        '{fwrm_pkg::KIND_PUSH,  32'h5555_5555, 11, 1'b0, '0},
        '{fwrm_pkg::KIND_PUSH,  32'hAAAA_AAAA, 1,  1'b1, '{32'sd0,   WORD_MAX, 1'b0, 1'b1}},
        '{KIND_UNUSED,          32'h5A5A_A5A5, 1,  1'b1, '{32'sd0,   WORD_MAX, 1'b0, 1'b0}},
        '{fwrm_pkg::KIND_POP,   32'sd0,        1,  1'b1, '{WORD_MIN, WORD_MAX, 1'b0, 1'b0}},
        '{fwrm_pkg::KIND_POP,   32'sd0,        1,  1'b0, '0},
        '{fwrm_pkg::KIND_PUSH,  32'h7FFF_FFFE, 1,  1'b0, '0},
        '{fwrm_pkg::KIND_QUERY, 32'sd0,        1,  1'b0, '0},
        '{fwrm_pkg::KIND_POP,   32'sd0,        14, 1'b0, '0},
        '{fwrm_pkg::KIND_POP,   32'sd0,        1,  1'b0, '0},
        '{fwrm_pkg::KIND_POP,   32'sd0,        1,  1'b1, '{32'sd0,   WORD_MIN, 1'b1, 1'b0}},
        '{fwrm_pkg::KIND_PUSH,  32'sd100,      1,  1'b0, '0},
        '{fwrm_pkg::KIND_PUSH,  -32'sd100,     1,  1'b0, '0},
        '{fwrm_pkg::KIND_PUSH,  32'sd50,       1,  1'b0, '0},
        '{fwrm_pkg::KIND_QUERY, 32'sd0,        1,  1'b0, '0},
        '{fwrm_pkg::KIND_POP,   32'sd0,        1,  1'b0, '0},
        '{fwrm_pkg::KIND_PUSH,  32'sh8000_0001, 1, 1'b0, '0},
        '{fwrm_pkg::KIND_POP,   32'sd0,        4,  1'b0, '0}
    };

    fifo_with_running_max dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic sword_t queue_max();
        sword_t m;
        m = WORD_MIN;
        foreach (queue_words[i])
            if (queue_words[i] > m)
                m = queue_words[i];
        return m;
    endfunction

    // advance the queue model by one operation and return its result
    function automatic op_result_t apply_op(input logic [1:0] kind, input sword_t value);
        op_result_t r;
        r = '0;
        case (kind)
            fwrm_pkg::KIND_PUSH: begin
                if (queue_words.size() >= fwrm_pkg::DEPTH)
                    r.full_err = 1'b1;
                else
                    queue_words.push_back(value);
            end
            fwrm_pkg::KIND_POP: begin
                if (queue_words.size() == 0)
                    r.empty_err = 1'b1;
                else
                    r.data = queue_words.pop_front();
            end
            fwrm_pkg::KIND_QUERY: r.data = queue_max();
            default: ;
        endcase
        r.cur_max = queue_max();
        return r;
    endfunction

    // offer one item, wait for the transfer, then record what should come back
    task automatic send_item(input logic [1:0] kind, input sword_t value,
                             input bit typed, input op_result_t typed_res);
        int gap;
        op_result_t r;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        r = apply_op(kind, value);
        pending_results.push_back(typed ? typed_res : r);
        case (kind)
            fwrm_pkg::KIND_PUSH:  n_push++;
            fwrm_pkg::KIND_POP:   n_pop++;
            fwrm_pkg::KIND_QUERY: n_query++;
            default:              n_unused++;
        endcase
        if (r.full_err)
            n_full++;
        if (r.empty_err)
            n_empty++;
        if (queue_words.size() > peak_fill)
            peak_fill = queue_words.size();
    endtask

    task automatic send_random(input int push_pct);
        logic [1:0] kind;
        sword_t value;
        int pick;
        pick = $urandom_range(99);
        if (pick < push_pct)
            kind = fwrm_pkg::KIND_PUSH;
        else if ($urandom_range(99) < 70)
            kind = fwrm_pkg::KIND_POP;
        else if ($urandom_range(99) < 75)
            kind = fwrm_pkg::KIND_QUERY;
        else
            kind = KIND_UNUSED;
        case ($urandom_range(9))
            0:       value = WORD_MIN;
            1:       value = WORD_MAX;
            2, 3:    value = $signed($urandom_range(40)) - 20;
            4:       value = WORD_MIN + $signed($urandom_range(15));
            5:       value = WORD_MAX - $signed($urandom_range(15));
            default: value = $urandom;
        endcase
        send_item(kind, value, 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // result side: random stall unless a long hold-off is running
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long hold-off, counted here so the sender keeps offering meanwhile
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        op_result_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.data      = m_tdata[31:0];
                got.cur_max   = m_tdata[63:32];
                got.empty_err = m_tuser[0];
                got.full_err  = m_tuser[1];
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result with nothing pending: data %0d max %0d",
                                         got.data, got.cur_max));
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (got.data !== want.data)
                        flag_error($sformatf("data %0d, want %0d", got.data, want.data));
                    if (got.cur_max !== want.cur_max)
                        flag_error($sformatf("current_max %0d, want %0d",
                                             got.cur_max, want.cur_max));
                    if (got.empty_err !== want.empty_err)
                        flag_error($sformatf("empty_error %b, want %b",
                                             got.empty_err, want.empty_err));
                    if (got.full_err !== want.full_err)
                        flag_error($sformatf("full_error %b, want %b",
                                             got.full_err, want.full_err));
                end
            end
        end
    end

    initial begin
        int phase_tx [4];
        int phase_rx [4];
        int push_pct;
        phase_tx     = '{0, 51, 0, 29};
        phase_rx     = '{0, 0, 51, 29};
        errors       = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_go      = 1'b0;
        n_push = 0; n_pop = 0; n_query = 0; n_unused = 0;
        n_full = 0; n_empty = 0; peak_fill = 0; n_checked = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = fwrm_pkg::KIND_PUSH;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            repeat (dir_rows[i].reps)
                send_item(dir_rows[i].kind, dir_rows[i].value,
                          dir_rows[i].typed, dir_rows[i].res);
        wait_drained();

        // hold the result side off while items, mostly pushes, keep coming: input must stall
        hold_go = 1'b1;
        repeat (HOLD_ITEMS) send_random(80);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            push_pct     = 50;
            for (int n = 0; n < RAND_ITEMS / 4; n++) begin
                // swing between filling and emptying to reach both edges
                if (n % 32 == 0)
                    case ($urandom_range(3))
                        0:       push_pct = 25;
                        1:       push_pct = 50;
                        2:       push_pct = 75;
                        default: push_pct = 90;
                    endcase
                send_random(push_pct);
            end
            wait_drained();
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        repeat (100) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d pushes, %0d pops, %0d queries, %0d unused, %0d results checked",
                 n_push, n_pop, n_query, n_unused, n_checked);
        $display("Hit full %0d times, popped empty %0d times, peak fill %0d of %0d",
                 n_full, n_empty, peak_fill, fwrm_pkg::DEPTH);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fwrm_pkg.sv
rtl/fwrm_ram.sv
rtl/fwrm_cmp.sv
rtl/fifo_with_running_max.sv
bench/tb_fifo_with_running_max.sv
